### hw/rtl/zrp_pkg.sv
// Shared constants, types and tables for the normalized Zernike radial polynomial block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package zrp_pkg;

	// Highest radial order that is evaluated; larger orders are out of domain.
	localparam int N_MAX = 12;

	// Port field widths.
	localparam int RADIUS_W = 18;
	localparam int ORDER_W  = 4;
	localparam int REP_W    = 5;
	localparam int VALUE_W  = 20;

	// Radius magnitude inside the domain (0..1.0 in Q16) and its square.
	localparam int R_W     = 17;
	localparam int S_W     = 33;
	localparam int ONE_Q16 = 65536;

	// Coefficients, accumulator and the shared multiplier.
	localparam int BIN_W  = 13;
	localparam int COEF_W = 17;
	localparam int MAG_W  = 43;
	localparam int ACC_W  = MAG_W + 1;
	localparam int MB_W   = 20;
	localparam int PROD_W = MAG_W + MB_W;
	localparam int NORM_W = 19;
	localparam int K_W    = 3;

	localparam int VALUE_MAX = 524287;
	localparam int VALUE_NEG = 524288;
	localparam int SQRT2_Q16 = 92682;

	// round(sqrt(2n+2) * 65536) for n = 0..15.
	localparam logic [NORM_W-1:0] NORM_TAB [16] = '{
		19'd92682,  19'd131072, 19'd160530, 19'd185364,
		19'd207243, 19'd227023, 19'd245213, 19'd262144,
		19'd278046, 19'd293086, 19'd307391, 19'd321060,
		19'd334169, 19'd346784, 19'd358955, 19'd370728
	};

	// Binomial coefficients C(i, j), indexed by {i, j}, built as Pascal's triangle.
	typedef logic [BIN_W-1:0] binom_tab_t [256];

	function automatic binom_tab_t binom_table();
		binom_tab_t t;
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 16; j++) begin
				if (j == 0) begin
					t[i*16+j] = BIN_W'(1);
				end else if (i == 0) begin
					t[i*16+j] = '0;
				end else begin
					t[i*16+j] = t[(i-1)*16+j-1] + t[(i-1)*16+j];
				end
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM_TAB = binom_table();

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQUARE,
		OP_INIT,
		OP_H_LO,
		OP_H_HI,
		OP_H_ADD,
		OP_P_MUL,
		OP_P_RND,
		OP_S_MUL,
		OP_S_RND,
		OP_N_MUL,
		OP_FINISH
	} dp_op_t;

	// Operand class found at load time.
	typedef enum logic [1:0] {
		CLS_INVALID,
		CLS_ODD,
		CLS_ZERO,
		CLS_NORMAL
	} cls_t;

	typedef struct packed {
		dp_op_t         op;
		logic [K_W-1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		cls_t               cls;
		logic [K_W-1:0]     lo;
		logic [ORDER_W-1:0] a;
	} dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/zrp_operand_if.sv
// Operand channel: valid/ready handshake carrying radius, order and repetition.
// Depends on zrp_pkg for the field widths.
`default_nettype none

interface zrp_operand_if;
	import zrp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [RADIUS_W-1:0] radius;
	logic [ORDER_W-1:0]         order;
	logic signed [REP_W-1:0]    repetition;

	modport source (output valid, output radius, output order, output repetition,
		input ready);
	modport sink (input valid, input radius, input order, input repetition,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/zrp_result_if.sv
// Result channel: valid/ready handshake carrying the value and the domain flag.
// Depends on zrp_pkg for the field widths.
`default_nettype none

interface zrp_result_if;
	import zrp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      in_domain;

	modport source (output valid, output value, output in_domain, input ready);
	modport sink (input valid, input value, input in_domain, output ready);
endinterface

`default_nettype wire

### hw/rtl/zrp_dp.sv
// Datapath: operand decode, coefficient lookup, one shared 43x20 multiplier,
// Horner accumulator, power of r, normalization and the result register.
// Depends on zrp_pkg; driven by zrp_ctrl through a command struct.
`default_nettype none

module zrp_dp (
	input  wire                                 clk,
	input  wire zrp_pkg::dp_cmd_t               cmd,
	input  wire signed [zrp_pkg::RADIUS_W-1:0]  radius,
	input  wire [zrp_pkg::ORDER_W-1:0]          order,
	input  wire signed [zrp_pkg::REP_W-1:0]     repetition,
	output zrp_pkg::dp_stat_t                   stat,
	output logic signed [zrp_pkg::VALUE_W-1:0]  value,
	output logic                                in_domain
);
	import zrp_pkg::*;

	// Operand registers.
	logic [R_W-1:0]     r_q;
	logic [ORDER_W-1:0] n_q;
	logic [ORDER_W-1:0] a_q;
	logic [K_W-1:0]     lo_q;
	cls_t               cls_q;

	// Working registers.
	logic [S_W-1:0]           s_q;
	logic [COEF_W-1:0]        coef_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [R_W-1:0]           p_q;
	logic [PROD_W-1:0]        prod_q;
	logic [MAG_W-1:0]         lowr_q;

	// Decode of the incoming operands.
	logic [REP_W-1:0]   a_full;
	logic [ORDER_W-1:0] diff;
	logic               ok;
	cls_t               cls_d;

	always_comb begin
		a_full = repetition[REP_W-1] ? REP_W'(-repetition) : REP_W'(repetition);
		diff   = order - a_full[ORDER_W-1:0];
		ok     = !radius[RADIUS_W-1] && (radius[R_W-1:0] <= R_W'(ONE_Q16)) &&
			(order <= ORDER_W'(N_MAX)) && (a_full <= {1'b0, order});
		if (!ok) begin
			cls_d = CLS_INVALID;
		end else if (diff[0]) begin
			cls_d = CLS_ODD;
		end else if (order == '0) begin
			cls_d = CLS_ZERO;
		end else begin
			cls_d = CLS_NORMAL;
		end
	end

	assign stat.cls = cls_q;
	assign stat.lo  = lo_q;
	assign stat.a   = a_q;

	// Coefficient c_k = C(n-k, k) * C(n-2k, lo-k), looked up for the commanded k.
	logic [ORDER_W-1:0]   k_ext;
	logic [ORDER_W-1:0]   row1;
	logic [ORDER_W-1:0]   row2;
	logic [ORDER_W-1:0]   col2;
	logic [2*BIN_W-1:0]   coef_full;

	always_comb begin
		k_ext     = {1'b0, cmd.k};
		row1      = n_q - k_ext;
		row2      = n_q - {cmd.k, 1'b0};
		col2      = {1'b0, lo_q - cmd.k};
		coef_full = (2*BIN_W)'(BINOM_TAB[{row1, k_ext}]) *
			(2*BIN_W)'(BINOM_TAB[{row2, col2}]);
	end

	// Accumulator magnitude and sign.
	logic [MAG_W-1:0] acc_mag;
	logic             acc_neg;

	assign acc_neg = acc_q[ACC_W-1];
	assign acc_mag = acc_neg ? MAG_W'(-acc_q) : MAG_W'(acc_q);

	// Shared multiplier operand selection.
	logic [MAG_W-1:0]  mul_a;
	logic [MB_W-1:0]   mul_b;
	logic              mul_en;
	logic [PROD_W-1:0] mul_p;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			OP_SQUARE: begin
				mul_a = MAG_W'(r_q);
				mul_b = MB_W'(r_q);
			end
			OP_H_LO: begin
				mul_a = acc_mag;
				mul_b = MB_W'(s_q[15:0]);
			end
			OP_H_HI: begin
				mul_a = acc_mag;
				mul_b = MB_W'(s_q[S_W-1:16]);
			end
			OP_P_MUL: begin
				mul_a = MAG_W'(p_q);
				mul_b = MB_W'(r_q);
			end
			OP_S_MUL: begin
				mul_a = acc_mag;
				mul_b = MB_W'(p_q);
			end
			OP_N_MUL: begin
				mul_a = acc_mag;
				mul_b = MB_W'(NORM_TAB[n_q]);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Rounded shifts of the registered product, ties away from zero on magnitudes.
	logic [PROD_W-1:0]       rnd16;
	logic [PROD_W-1:0]       rnd24;
	logic [PROD_W-1:0]       h_t;
	logic [PROD_W-1:0]       h_mag;
	logic signed [ACC_W-1:0] h_signed;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] s_signed;

	always_comb begin
		rnd16    = (prod_q + PROD_W'(32'h0000_8000)) >> 16;
		rnd24    = (prod_q + PROD_W'(32'h0080_0000)) >> 24;
		h_t      = prod_q + PROD_W'(lowr_q);
		h_mag    = (h_t + PROD_W'(32'h0000_8000)) >> 16;
		h_signed = acc_neg ? -ACC_W'(h_mag[MAG_W-1:0]) : ACC_W'(h_mag[MAG_W-1:0]);
		term     = ACC_W'({coef_q, 24'b0});
		s_signed = acc_neg ? -ACC_W'(rnd16[MAG_W-1:0]) : ACC_W'(rnd16[MAG_W-1:0]);
	end

	// Saturated final value.
	logic signed [VALUE_W-1:0] sat_value;

	always_comb begin
		if (!acc_neg) begin
			if (rnd24 > PROD_W'(VALUE_MAX)) begin
				sat_value = VALUE_W'(VALUE_MAX);
			end else begin
				sat_value = rnd24[VALUE_W-1:0];
			end
		end else begin
			if (rnd24 > PROD_W'(VALUE_NEG)) begin
				sat_value = VALUE_W'(VALUE_NEG);
			end else begin
				sat_value = -rnd24[VALUE_W-1:0];
			end
		end
	end

	// Coefficient register follows the commanded index every cycle.
	always_ff @(posedge clk) begin
		coef_q <= coef_full[COEF_W-1:0];
	end

	// Product register of the shared multiplier.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
	end

	// Operand, accumulator, power and result registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				r_q   <= radius[R_W-1:0];
				n_q   <= order;
				a_q   <= a_full[ORDER_W-1:0];
				lo_q  <= diff[ORDER_W-1:1];
				cls_q <= cls_d;
			end
			OP_INIT: begin
				s_q   <= prod_q[S_W-1:0];
				acc_q <= term;
				p_q   <= R_W'(ONE_Q16);
			end
			OP_H_HI: begin
				lowr_q <= rnd16[MAG_W-1:0];
			end
			OP_H_ADD: begin
				acc_q <= cmd.k[0] ? h_signed - term : h_signed + term;
			end
			OP_P_RND: begin
				p_q <= rnd16[R_W-1:0];
			end
			OP_S_RND: begin
				acc_q <= s_signed;
			end
			OP_FINISH: begin
				case (cls_q)
					CLS_NORMAL: begin
						value     <= sat_value;
						in_domain <= 1'b1;
					end
					CLS_ZERO: begin
						value     <= VALUE_W'(SQRT2_Q16);
						in_domain <= 1'b1;
					end
					CLS_ODD: begin
						value     <= '0;
						in_domain <= 1'b1;
					end
					default: begin
						value     <= '0;
						in_domain <= 1'b0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/zrp_ctrl.sv
// Controller: sequences load, squaring, Horner steps, power of r, scaling and
// normalization, and owns both handshakes. Depends on zrp_pkg.
`default_nettype none

module zrp_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	input  wire zrp_pkg::dp_stat_t  stat,
	output zrp_pkg::dp_cmd_t        cmd
);
	import zrp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SQUARE,
		ST_INIT,
		ST_H_LO,
		ST_H_HI,
		ST_H_ADD,
		ST_P_MUL,
		ST_P_RND,
		ST_S_MUL,
		ST_S_RND,
		ST_N_MUL,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [K_W-1:0]       k_q;
	logic [ORDER_W-1:0]   j_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd.k  = k_q;
		cmd.op = OP_NOP;
		case (state_q)
			ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NOP;
			ST_SQUARE: cmd.op = OP_SQUARE;
			ST_INIT:   cmd.op = OP_INIT;
			ST_H_LO:   cmd.op = OP_H_LO;
			ST_H_HI:   cmd.op = OP_H_HI;
			ST_H_ADD:  cmd.op = OP_H_ADD;
			ST_P_MUL:  cmd.op = OP_P_MUL;
			ST_P_RND:  cmd.op = OP_P_RND;
			ST_S_MUL:  cmd.op = OP_S_MUL;
			ST_S_RND:  cmd.op = OP_S_RND;
			ST_N_MUL:  cmd.op = OP_N_MUL;
			ST_FINISH: cmd.op = slot_free ? OP_FINISH : OP_NOP;
			default:   cmd.op = OP_NOP;
		endcase
	end

	// State, loop counters and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills on a finish and empties on a result transaction.
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					k_q <= '0;
					j_q <= '0;
					state_q <= (stat.cls == CLS_NORMAL) ? ST_SQUARE : ST_FINISH;
				end
				ST_SQUARE: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					if (stat.lo != '0) begin
						k_q     <= K_W'(1);
						state_q <= ST_H_LO;
					end else begin
						state_q <= (stat.a != '0) ? ST_P_MUL : ST_S_MUL;
					end
				end
				ST_H_LO: begin
					state_q <= ST_H_HI;
				end
				ST_H_HI: begin
					state_q <= ST_H_ADD;
				end
				ST_H_ADD: begin
					if (k_q == stat.lo) begin
						state_q <= (stat.a != '0) ? ST_P_MUL : ST_S_MUL;
					end else begin
						k_q     <= k_q + K_W'(1);
						state_q <= ST_H_LO;
					end
				end
				ST_P_MUL: begin
					state_q <= ST_P_RND;
				end
				ST_P_RND: begin
					j_q     <= j_q + ORDER_W'(1);
					state_q <= (ORDER_W'(j_q + ORDER_W'(1)) == stat.a) ? ST_S_MUL : ST_P_MUL;
				end
				ST_S_MUL: begin
					state_q <= ST_S_RND;
				end
				ST_S_RND: begin
					state_q <= ST_N_MUL;
				end
				ST_N_MUL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The Horner index stays within 1..lo while terms are being added.
	a_horner_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_H_LO || state_q == ST_H_HI || state_q == ST_H_ADD) |->
		(k_q != '0 && k_q <= stat.lo))
		else $error("Horner index outside 1..lo");

	// Power steps run only while fewer than |m| multiplies are done.
	a_power_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_MUL || state_q == ST_P_RND) |-> (j_q < stat.a))
		else $error("power of r step beyond |m|");

	// A result is written only into a free or draining output register, and then shows.
	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |-> (!out_valid_q || out_ready) ##1 out_valid_q)
		else $error("result written over a pending transaction");

	// A computed result always comes through normalization first.
	a_normal_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && $past(state_q) != ST_FINISH &&
		stat.cls == CLS_NORMAL) |-> ($past(state_q) == ST_N_MUL))
		else $error("normal operand reached finish without normalization");

endmodule

`default_nettype wire

### hw/rtl/zernike_radial_polynomial.sv
// Normalized Zernike radial polynomial sqrt(2n+2)*R_n^|m|(r) in fixed point. The block
// accepts one operand transaction (Q1.16 radius, order n, repetition m) and returns one
// result transaction (Q3.16 value, saturated, and a domain flag). Work is done by a
// controller and a datapath around one shared 43x20 multiplier. An operand is taken only in
// the idle state, so a new operand waits until the previous result is in the output register;
// a valid operand with even n-|m| and n>0 goes through squaring, a low, high and add step
// per Horner term in r^2, a multiply and a rounding step per factor of r for r^|m|, scaling
// and normalization; out-of-domain operands, odd n-|m| and n=0 go straight to the finish. A
// finished result waits in the output register while the next operand is already being
// accepted and computed. Depends on zrp_pkg, zrp_operand_if, zrp_result_if, zrp_ctrl and zrp_dp.
`default_nettype none

module zernike_radial_polynomial (
	input  wire           clk,
	input  wire           arst_n,
	zrp_operand_if.sink   operand,
	zrp_result_if.source  result
);
	import zrp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;
	logic     out_valid;

	// Sequencer and handshakes.
	zrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and result register.
	zrp_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.radius     (operand.radius),
		.order      (operand.order),
		.repetition (operand.repetition),
		.stat       (stat),
		.value      (result.value),
		.in_domain  (result.in_domain)
	);

	assign operand.ready = in_ready;
	assign result.valid  = out_valid;

endmodule

`default_nettype wire

### tb/zrp_checker.sv
// Checker for the Zernike radial polynomial block: watches both channels and predicts results.
// Each accepted result is compared with the oldest predicted one.
// Depends on zrp_pkg, zrp_operand_if and zrp_result_if.

module zrp_checker
	import zrp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	zrp_operand_if operand,
	zrp_result_if  result,
	output int     fail_count,
	output int     pending
);

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      in_domain;
	} radial_result_t;

	// round(sqrt(2n+2) * 2^16) for every order n.
	localparam u64_t NORM_Q16 [16] = '{
		92682, 131072, 160530, 185364, 207243, 227023, 245213, 262144,
		278046, 293086, 307391, 321060, 334169, 346784, 358955, 370728
	};

	radial_result_t radial_expected [$];

	function automatic u64_t factorial(input int i);
		u64_t f;
		f = 1;
		for (int j = 2; j <= i; j++) begin
			f = f * u64_t'(j);
		end
		return f;
	endfunction

	// Rounds v * f / 2^sh to nearest, ties away from zero.
	function automatic longint round_scale(input longint v, input u64_t f, input int sh);
		bit   neg;
		u64_t mag;
		neg = v < 0;
		mag = neg ? u64_t'(-v) : u64_t'(v);
		mag = (mag * f + (u64_t'(1) << (sh - 1))) >> sh;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	// Normalized radial polynomial of one operand transaction.
	function automatic radial_result_t radial_value(input logic signed [RADIUS_W-1:0] rad,
		input logic [ORDER_W-1:0] ord, input logic signed [REP_W-1:0] rep);
		radial_result_t res_out;
		longint         r, acc, term, sum;
		u64_t           s, p, c, mag, t;
		int             n, mi, a, half, lo;
		bit             neg;
		r = longint'(rad);
		n = int'(ord);
		mi = int'(rep);
		a = (mi < 0) ? -mi : mi;
		res_out.value = '0;
		res_out.in_domain = 1'b0;
		if (r < 0 || r > ONE_Q16 || n > N_MAX || a > n) begin
			return res_out;
		end
		res_out.in_domain = 1'b1;
		// An odd n-|m| gives a zero polynomial.
		if (((n - a) % 2) != 0) begin
			return res_out;
		end
		if (n == 0) begin
			res_out.value = VALUE_W'(SQRT2_Q16);
			return res_out;
		end
		half = (n + a) / 2;
		lo = (n - a) / 2;
		s = u64_t'(r) * u64_t'(r);

		// Horner's rule in r^2 with the accumulator in Q24.
		acc = 0;
		for (int k = 0; k <= lo; k++) begin
			c = factorial(n - k) / (factorial(k) * factorial(half - k) * factorial(lo - k));
			term = longint'(c) <<< 24;
			if (k > 0) begin
				neg = acc < 0;
				mag = neg ? u64_t'(-acc) : u64_t'(acc);
				t = mag * (s >> 16) + ((mag * (s & 64'hFFFF) + 64'h8000) >> 16);
				t = (t + 64'h8000) >> 16;
				acc = neg ? -longint'(t) : longint'(t);
			end
			acc = acc + (((k % 2) != 0) ? -term : term);
		end

		// Multiply by r^|m| and by the normalization, then saturate.
		p = 65536;
		for (int k = 0; k < a; k++) begin
			p = (p * u64_t'(r) + 64'h8000) >> 16;
		end
		acc = round_scale(acc, p, 16);
		sum = round_scale(acc, NORM_Q16[n], 24);
		if (sum > VALUE_MAX) begin
			sum = VALUE_MAX;
		end
		if (sum < -VALUE_NEG) begin
			sum = -VALUE_NEG;
		end
		res_out.value = sum[VALUE_W-1:0];
		return res_out;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Compare each result transaction, then record the prediction for a new operand.
	always @(posedge clk) begin
		radial_result_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (radial_expected.size() == 0) begin
					report_mismatch("result transaction with none pending",
						int'(result.value), 0);
				end else begin
					want = radial_expected.pop_front();
					if (result.value !== want.value) begin
						report_mismatch("value", int'(result.value), int'(want.value));
					end
					if (result.in_domain !== want.in_domain) begin
						report_mismatch("in_domain", int'(result.in_domain),
							int'(want.in_domain));
					end
				end
			end
			if (operand.valid && operand.ready) begin
				radial_expected.push_back(radial_value(operand.radius, operand.order,
					operand.repetition));
			end
			pending <= radial_expected.size();
		end else begin
			fail_count = 0;
			pending <= 0;
		end
	end

endmodule

### tb/tb_top.sv
// Top of the testbench: clock, reset, operand stimulus, result back-pressure and verdict.
// Depends on zrp_pkg, both channel interfaces, zrp_checker and zernike_radial_polynomial.

module tb_top;
	import zrp_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;

	zrp_operand_if operand_ch ();
	zrp_result_if  result_ch ();

	zernike_radial_polynomial uut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	zrp_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand   (operand_ch),
		.result    (result_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// Offer one operand transaction and hold it until it is accepted.
	task automatic send_operand(input int r, input int n, input int m);
		operand_ch.valid <= 1'b1;
		operand_ch.radius <= r[RADIUS_W-1:0];
		operand_ch.order <= n[ORDER_W-1:0];
		operand_ch.repetition <= m[REP_W-1:0];
		@(posedge clk);
		while (!operand_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// The receiver switches between no stalls, short stalls and long stalls.
	initial begin
		int stall_left;
		int phase_left;
		int mode;
		stall_left = 0;
		phase_left = 0;
		mode = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (phase_left == 0) begin
					mode = $urandom_range(0, 2);
					phase_left = $urandom_range(50, 300);
				end
				phase_left--;
				case (mode)
					1: begin
						if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
					end
					2: begin
						if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Directed operands first, then random bursts, most of them separated by gaps.
	initial begin
		int r, n, m, a, sel, gap, burst_left;
		arst_n <= 1'b0;
		operand_ch.valid <= 1'b0;
		operand_ch.radius <= '0;
		operand_ch.order <= '0;
		operand_ch.repetition <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Order zero, both ends of the radius, the largest order and interior operands.
		send_operand(0, 0, 0);
		send_operand(65536, 0, 0);
		send_operand(65536, 12, 0);
		send_operand(65536, 12, 12);
		send_operand(65536, 12, -12);
		send_operand(0, 12, 0);
		send_operand(32768, 2, 0);
		send_operand(32768, 4, 2);
		send_operand(65535, 12, -2);
		send_operand(65536, 1, -1);
		send_operand(12345, 6, 4);
		send_operand(20000, 10, 0);
		send_operand(40000, 1, 1);
		// Radius outside the unit interval.
		send_operand(-1, 2, 0);
		send_operand(65537, 2, 0);
		send_operand(-131072, 4, 0);
		send_operand(131071, 4, 0);
		// Order above the limit, and repetition larger than the order.
		send_operand(40000, 13, 1);
		send_operand(40000, 15, 15);
		send_operand(40000, 3, 5);
		send_operand(40000, 5, -16);
		send_operand(40000, 12, -15);
		// Odd n-|m|.
		send_operand(40000, 5, 2);
		send_operand(40000, 1, 0);

		burst_left = 0;
		for (int i = 0; i < 1550; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					operand_ch.valid <= 1'b0;
					operand_ch.radius <= RADIUS_W'($urandom);
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;

			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				// Well-formed operand with even n-|m|.
				n = $urandom_range(0, N_MAX);
				a = n - 2 * $urandom_range(0, n / 2);
				m = $urandom_range(0, 1) ? -a : a;
			end else if (sel < 88) begin
				// Valid operand with odd n-|m|.
				n = $urandom_range(1, N_MAX);
				a = n - 1 - 2 * $urandom_range(0, (n - 1) / 2);
				m = $urandom_range(0, 1) ? -a : a;
			end else if (sel < 93) begin
				// Repetition magnitude at or above the order, with orders up to 15.
				n = $urandom_range(0, 15);
				m = $urandom_range(0, 1) ? -$urandom_range(n, 16) : $urandom_range(n, 15);
			end else begin
				n = $urandom_range(0, 15);
				m = $urandom_range(0, 31);
			end
			case ($urandom_range(0, 9))
				0: r = 0;
				1: r = 65536;
				2: r = $urandom_range(65000, 65536);
				3: r = (sel >= 93) ? int'($urandom) : $urandom_range(0, 65536);
				default: r = $urandom_range(0, 65536);
			endcase
			if (sel >= 97) begin
				r = $urandom_range(0, 1) ? -$urandom_range(1, 131072)
					: $urandom_range(65537, 131071);
			end
			send_operand(r, n, m);
		end
		operand_ch.valid <= 1'b0;
		@(posedge clk);

		// Drain the outstanding results, then allow for the block's latency.
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("[zernike_radial_polynomial] OK");
		end else begin
			$display("[zernike_radial_polynomial] ERROR");
		end
		$finish;
	end

	// Watchdog in case the handshakes hang.
	initial begin
		#8000000;
		$display("[zernike_radial_polynomial] ERROR");
		$finish;
	end

endmodule
